@@ rtl/core/tclb_pkg.sv @@
// ----------------------------------------------------------------------------
// Tree child list builder package
// Shared constants, command and status codes, sequencer states and the result
// bundle of the tree child list builder.
// ----------------------------------------------------------------------------
`default_nettype none

package tclb_pkg;

  localparam int unsigned MAX_NODES  = 1024;
  localparam int unsigned IDX_W      = $clog2(MAX_NODES);
  localparam int unsigned SLOT_DEPTH = MAX_NODES + 1;
  localparam int unsigned NUM_W      = 11;

  localparam logic [NUM_W-1:0] MAX_NODES_N = NUM_W'(MAX_NODES);
  localparam logic [NUM_W-1:0] ROOT_IDX    = '1;
  localparam logic [NUM_W-1:0] CNT_SAT     = '1;

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [2:0] {
    REQ_SET_PARENT = 3'd0,
    REQ_BUILD      = 3'd1,
    REQ_READ_SLOT  = 3'd2,
    REQ_QUERY      = 3'd3,
    REQ_CLEAR      = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_RANGE    = 3'd1,
    STS_TWICE    = 3'd2,
    STS_MISMATCH = 3'd3,
    STS_CYCLE    = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_SP_CHK,
    ST_SP_INC,
    ST_BC_RD,
    ST_BC_CHK,
    ST_PF_RD,
    ST_PF_WR,
    ST_SC_RDP,
    ST_SC_RDO,
    ST_SC_WR,
    ST_DP_RD,
    ST_DP_CNT,
    ST_WK_RD,
    ST_WK_CHK,
    ST_Q_RD,
    ST_Q_DATA,
    ST_SL_DATA,
    ST_DONE
  } state_t;

  typedef struct packed {
    status_t    status;
    idx_t       child_node;
    num_t       child_count;
    num_t       first_child;
    num_t       depth;
    num_t       leaf_total;
    num_t       tree_height;
  } rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/tclb_ram.sv @@
// ----------------------------------------------------------------------------
// Tree child list builder table memory
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tclb_ram #(
  parameter int unsigned DW    = 11,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/tclb_seq.sv @@
// ----------------------------------------------------------------------------
// Tree child list builder sequencer
// Owns the parent, count, offset and children tables and steps through every
// command in a sequence of states.
// ----------------------------------------------------------------------------
`default_nettype none

module tclb_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [10:0]         cfg_data,
  input  wire logic                cmd_valid,
  output logic                     cmd_ready,
  input  wire logic [2:0]          cmd_type,
  input  wire logic [10:0]         cmd_node,
  input  wire logic [10:0]         cmd_parent,
  input  wire logic [9:0]          cmd_slot,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output tclb_pkg::rsp_t           rsp
);

  import tclb_pkg::*;

  localparam int unsigned CAW = $clog2(SLOT_DEPTH);

  state_t  state_r, state_nxt;
  req_t    req_r, req_nxt;
  num_t    node_r, node_nxt;
  num_t    par_r, par_nxt;
  num_t    idx_r, idx_nxt;
  num_t    acc_r, acc_nxt;
  idx_t    cur_r, cur_nxt;
  num_t    dep_r, dep_nxt;
  num_t    leaves_r, leaves_nxt;
  num_t    htmp_r, htmp_nxt;
  logic    pass_r, pass_nxt;
  status_t status_r, status_nxt;
  idx_t    child_r, child_nxt;
  num_t    cnt_out_r, cnt_out_nxt;
  num_t    first_out_r, first_out_nxt;
  num_t    depth_out_r, depth_out_nxt;
  logic    built_r, built_nxt;
  num_t    leaf_r, leaf_nxt;
  num_t    height_r, height_nxt;
  num_t    nc_r, nc_nxt;
  num_t    clr_addr_r, clr_addr_nxt;
  logic    clr_resp_r, clr_resp_nxt;

  logic              p_we;
  idx_t              p_waddr, p_raddr;
  logic [NUM_W:0]    p_wdata, p_rdata;
  logic              c_we;
  logic [CAW-1:0]    c_waddr, c_raddr;
  num_t              c_wdata, c_rdata;
  logic              o_we;
  logic [CAW-1:0]    o_waddr, o_raddr;
  num_t              o_wdata, o_rdata;
  logic              h_we;
  idx_t              h_waddr, h_raddr, h_wdata, h_rdata;

  num_t n_act;
  num_t p_par;
  num_t sum;
  num_t node_inc;
  num_t par_inc;

  tclb_ram #(.DW(NUM_W + 1), .DEPTH(MAX_NODES)) u_parent (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  tclb_ram #(.DW(NUM_W), .DEPTH(SLOT_DEPTH)) u_count (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  tclb_ram #(.DW(NUM_W), .DEPTH(SLOT_DEPTH)) u_offset (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .raddr(o_raddr), .rdata(o_rdata)
  );

  tclb_ram #(.DW(IDX_W), .DEPTH(MAX_NODES)) u_children (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  assign n_act    = (nc_r > MAX_NODES_N) ? MAX_NODES_N : nc_r;
  assign p_par    = p_rdata[NUM_W-1:0];
  assign sum      = acc_r + c_rdata;
  assign node_inc = node_r + NUM_W'(1);
  assign par_inc  = par_r + NUM_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      built_r    <= 1'b0;
      leaf_r     <= '0;
      height_r   <= '0;
      nc_r       <= MAX_NODES_N;
      clr_addr_r <= '0;
      clr_resp_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      built_r    <= built_nxt;
      leaf_r     <= leaf_nxt;
      height_r   <= height_nxt;
      nc_r       <= nc_nxt;
      clr_addr_r <= clr_addr_nxt;
      clr_resp_r <= clr_resp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    node_r      <= node_nxt;
    par_r       <= par_nxt;
    idx_r       <= idx_nxt;
    acc_r       <= acc_nxt;
    cur_r       <= cur_nxt;
    dep_r       <= dep_nxt;
    leaves_r    <= leaves_nxt;
    htmp_r      <= htmp_nxt;
    pass_r      <= pass_nxt;
    status_r    <= status_nxt;
    child_r     <= child_nxt;
    cnt_out_r   <= cnt_out_nxt;
    first_out_r <= first_out_nxt;
    depth_out_r <= depth_out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    node_nxt      = node_r;
    par_nxt       = par_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    cur_nxt       = cur_r;
    dep_nxt       = dep_r;
    leaves_nxt    = leaves_r;
    htmp_nxt      = htmp_r;
    pass_nxt      = pass_r;
    status_nxt    = status_r;
    child_nxt     = child_r;
    cnt_out_nxt   = cnt_out_r;
    first_out_nxt = first_out_r;
    depth_out_nxt = depth_out_r;
    built_nxt     = built_r;
    leaf_nxt      = leaf_r;
    height_nxt    = height_r;
    nc_nxt        = nc_r;
    clr_addr_nxt  = clr_addr_r;
    clr_resp_nxt  = clr_resp_r;

    p_we    = 1'b0;
    p_waddr = '0;
    p_wdata = '0;
    p_raddr = '0;
    c_we    = 1'b0;
    c_waddr = '0;
    c_wdata = '0;
    c_raddr = '0;
    o_we    = 1'b0;
    o_waddr = '0;
    o_wdata = '0;
    o_raddr = '0;
    h_we    = 1'b0;
    h_waddr = '0;
    h_wdata = '0;
    h_raddr = '0;

    unique case (state_r)
      ST_CLR: begin
        p_we    = !clr_addr_r[NUM_W-1];
        p_waddr = clr_addr_r[IDX_W-1:0];
        p_wdata = {1'b0, ROOT_IDX};
        c_we    = 1'b1;
        c_waddr = clr_addr_r[CAW-1:0];
        o_we    = 1'b1;
        o_waddr = clr_addr_r[CAW-1:0];
        if (clr_addr_r == MAX_NODES_N) begin
          status_nxt = STS_OK;
          state_nxt  = clr_resp_r ? ST_DONE : ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + NUM_W'(1);
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          req_nxt       = req_t'(cmd_type);
          node_nxt      = cmd_node;
          par_nxt       = cmd_parent;
          status_nxt    = STS_OK;
          child_nxt     = '0;
          cnt_out_nxt   = '0;
          first_out_nxt = '0;
          depth_out_nxt = '0;
          idx_nxt       = '0;
          state_nxt     = ST_DONE;
          unique case (req_t'(cmd_type))
            REQ_SET_PARENT: begin
              if (cmd_node[NUM_W-1] || cmd_node >= n_act ||
                  (cmd_parent[NUM_W-1] && cmd_parent != ROOT_IDX) ||
                  (!cmd_parent[NUM_W-1] && cmd_parent >= n_act)) begin
                status_nxt = STS_RANGE;
              end else begin
                p_raddr   = cmd_node[IDX_W-1:0];
                state_nxt = ST_SP_CHK;
              end
            end
            REQ_BUILD: begin
              state_nxt = ST_BC_RD;
            end
            REQ_READ_SLOT: begin
              if ({1'b0, cmd_slot} >= n_act) begin
                status_nxt = STS_RANGE;
              end else if (!built_r) begin
                status_nxt = STS_MISMATCH;
              end else begin
                h_raddr   = cmd_slot;
                state_nxt = ST_SL_DATA;
              end
            end
            REQ_QUERY: begin
              if ((cmd_node[NUM_W-1] && cmd_node != ROOT_IDX) ||
                  (!cmd_node[NUM_W-1] && cmd_node >= n_act)) begin
                status_nxt = STS_RANGE;
              end else if (!built_r) begin
                status_nxt = STS_MISMATCH;
              end else if (cmd_node == ROOT_IDX) begin
                state_nxt = ST_Q_RD;
              end else begin
                cur_nxt   = cmd_node[IDX_W-1:0];
                dep_nxt   = NUM_W'(1);
                state_nxt = ST_WK_RD;
              end
            end
            REQ_CLEAR: begin
              built_nxt    = 1'b0;
              leaf_nxt     = '0;
              height_nxt   = '0;
              clr_addr_nxt = '0;
              clr_resp_nxt = 1'b1;
              state_nxt    = ST_CLR;
            end
            default: begin
              status_nxt = STS_RANGE;
            end
          endcase
        end
      end
      ST_SP_CHK: begin
        if (p_rdata[NUM_W]) begin
          status_nxt = STS_TWICE;
          state_nxt  = ST_DONE;
        end else begin
          p_we      = 1'b1;
          p_waddr   = node_r[IDX_W-1:0];
          p_wdata   = {1'b1, par_r};
          c_raddr   = par_inc[CAW-1:0];
          built_nxt = 1'b0;
          state_nxt = ST_SP_INC;
        end
      end
      ST_SP_INC: begin
        c_we      = (c_rdata != CNT_SAT);
        c_waddr   = par_inc[CAW-1:0];
        c_wdata   = c_rdata + NUM_W'(1);
        state_nxt = ST_DONE;
      end
      ST_BC_RD: begin
        if (idx_r == n_act) begin
          idx_nxt   = '0;
          acc_nxt   = '0;
          pass_nxt  = 1'b0;
          state_nxt = ST_PF_RD;
        end else begin
          p_raddr   = idx_r[IDX_W-1:0];
          state_nxt = ST_BC_CHK;
        end
      end
      ST_BC_CHK: begin
        if (!p_rdata[NUM_W] || (p_par[NUM_W-1] && p_par != ROOT_IDX) ||
            (!p_par[NUM_W-1] && p_par >= n_act)) begin
          status_nxt = STS_MISMATCH;
          state_nxt  = ST_DONE;
        end else begin
          idx_nxt   = idx_r + NUM_W'(1);
          state_nxt = ST_BC_RD;
        end
      end
      ST_PF_RD: begin
        if (idx_r == '0) begin
          o_we    = 1'b1;
          o_waddr = '0;
          o_wdata = '0;
        end
        if (idx_r == n_act) begin
          idx_nxt = '0;
          if (!pass_r) begin
            state_nxt = ST_SC_RDP;
          end else begin
            leaves_nxt = '0;
            htmp_nxt   = '0;
            state_nxt  = ST_DP_RD;
          end
        end else begin
          c_raddr   = idx_r[CAW-1:0];
          state_nxt = ST_PF_WR;
        end
      end
      ST_PF_WR: begin
        o_we      = 1'b1;
        o_waddr   = CAW'(idx_r + NUM_W'(1));
        o_wdata   = sum;
        acc_nxt   = sum;
        idx_nxt   = idx_r + NUM_W'(1);
        state_nxt = ST_PF_RD;
      end
      ST_SC_RDP: begin
        if (idx_r == n_act) begin
          idx_nxt   = '0;
          acc_nxt   = '0;
          pass_nxt  = 1'b1;
          state_nxt = ST_PF_RD;
        end else begin
          p_raddr   = idx_r[IDX_W-1:0];
          state_nxt = ST_SC_RDO;
        end
      end
      ST_SC_RDO: begin
        par_nxt   = p_par + NUM_W'(1);
        o_raddr   = CAW'(p_par + NUM_W'(1));
        state_nxt = ST_SC_WR;
      end
      ST_SC_WR: begin
        o_we      = 1'b1;
        o_waddr   = par_r[CAW-1:0];
        o_wdata   = o_rdata + NUM_W'(1);
        h_we      = (o_rdata < MAX_NODES_N);
        h_waddr   = o_rdata[IDX_W-1:0];
        h_wdata   = idx_r[IDX_W-1:0];
        idx_nxt   = idx_r + NUM_W'(1);
        state_nxt = ST_SC_RDP;
      end
      ST_DP_RD: begin
        if (idx_r == n_act) begin
          leaf_nxt   = leaves_r;
          height_nxt = htmp_r;
          built_nxt  = 1'b1;
          status_nxt = STS_OK;
          state_nxt  = ST_DONE;
        end else begin
          c_raddr   = CAW'(idx_r + NUM_W'(1));
          state_nxt = ST_DP_CNT;
        end
      end
      ST_DP_CNT: begin
        if (c_rdata == '0) begin
          leaves_nxt = leaves_r + NUM_W'(1);
        end
        cur_nxt   = idx_r[IDX_W-1:0];
        dep_nxt   = NUM_W'(1);
        state_nxt = ST_WK_RD;
      end
      ST_WK_RD: begin
        p_raddr   = cur_r;
        state_nxt = ST_WK_CHK;
      end
      ST_WK_CHK: begin
        if (p_par == ROOT_IDX) begin
          if (req_r == REQ_BUILD) begin
            if (dep_r > htmp_r) begin
              htmp_nxt = dep_r;
            end
            idx_nxt   = idx_r + NUM_W'(1);
            state_nxt = ST_DP_RD;
          end else begin
            depth_out_nxt = dep_r;
            state_nxt     = ST_Q_RD;
          end
        end else if (dep_r >= n_act || p_par[NUM_W-1] || p_par >= n_act) begin
          status_nxt = STS_CYCLE;
          if (req_r == REQ_BUILD) begin
            built_nxt = 1'b0;
          end
          state_nxt = ST_DONE;
        end else begin
          dep_nxt   = dep_r + NUM_W'(1);
          cur_nxt   = p_par[IDX_W-1:0];
          state_nxt = ST_WK_RD;
        end
      end
      ST_Q_RD: begin
        c_raddr   = node_inc[CAW-1:0];
        o_raddr   = node_inc[CAW-1:0];
        state_nxt = ST_Q_DATA;
      end
      ST_Q_DATA: begin
        cnt_out_nxt   = c_rdata;
        first_out_nxt = o_rdata;
        state_nxt     = ST_DONE;
      end
      ST_SL_DATA: begin
        child_nxt = h_rdata;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      nc_nxt       = cfg_data;
      built_nxt    = 1'b0;
      leaf_nxt     = '0;
      height_nxt   = '0;
      clr_addr_nxt = '0;
      clr_resp_nxt = 1'b0;
      state_nxt    = ST_CLR;
    end
  end

  assign cmd_ready = (state_r == ST_IDLE);
  assign rsp_valid = (state_r == ST_DONE);

  always_comb begin
    rsp.status      = status_r;
    rsp.child_node  = child_r;
    rsp.child_count = cnt_out_r;
    rsp.first_child = first_out_r;
    rsp.depth       = depth_out_r;
    rsp.leaf_total  = built_r ? leaf_r : '0;
    rsp.tree_height = built_r ? height_r : '0;
  end

endmodule

`default_nettype wire

@@ rtl/core/tree_child_list_builder_core.sv @@
// ----------------------------------------------------------------------------
// Tree child list builder core
// Keeps a tree as a parent table and builds per-node child lists on request.
//
// Commands arrive on the in_ channel, one transaction each, and every command
// returns exactly one result transaction on the out_ channel. The cfg_ channel
// writes the node count and clears the tree; it is always ready.
// All tables live in memories with one write and one read port, walked by one
// sequencer. A build runs a check pass, two offset passes, a scatter pass and
// a depth pass over the nodes, n being the node count.
// After reset and after a node count write the tables are swept, during which
// in_ready stays low.
// The result sits in an output register; the sequencer takes the next command
// as soon as the result has moved there. A stalled receiver holds the output
// register, and the sequencer then waits with the following result.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_child_list_builder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_node_count,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [10:0] in_node,
  input  wire logic [10:0] in_parent,
  input  wire logic [9:0]  in_slot,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [9:0]       out_child_node,
  output logic [10:0]      out_child_count,
  output logic [10:0]      out_first_child,
  output logic [10:0]      out_depth,
  output logic [10:0]      out_leaf_total,
  output logic [10:0]      out_tree_height
);

  import tclb_pkg::*;

  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;
  logic out_valid_r, out_valid_nxt;
  rsp_t out_r;

  assign cfg_ready = 1'b1;
  assign rsp_ready = !out_valid_r || out_ready;

  tclb_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_node_count),
    .cmd_valid  (in_valid),
    .cmd_ready  (in_ready),
    .cmd_type   (in_req_type),
    .cmd_node   (in_node),
    .cmd_parent (in_parent),
    .cmd_slot   (in_slot),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rsp_ready) begin
      out_valid_nxt = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && rsp_ready) begin
      out_r <= rsp;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_child_node  = out_r.child_node;
  assign out_child_count = out_r.child_count;
  assign out_first_child = out_r.first_child;
  assign out_depth       = out_r.depth;
  assign out_leaf_total  = out_r.leaf_total;
  assign out_tree_height = out_r.tree_height;

`ifndef ASSERT_OFF
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after a command transaction");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= STS_CYCLE)
    else $error("result status outside the defined codes");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STS_OK |->
      out_child_node == '0 && out_child_count == '0 &&
      out_first_child == '0 && out_depth == '0)
    else $error("failed command returned nonzero answer fields");

  a_leaf_height: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_leaf_total != '0 |-> out_tree_height != '0)
    else $error("leaves reported for a tree of zero height");
`endif

endmodule

`default_nettype wire

@@ test/tree_child_list_builder_core_tb.sv @@
// ----------------------------------------------------------------------------
// Tree child list builder core testbench
// Drives parent assignments, builds, slot reads, node queries and clears into
// the core under several node counts. It predicts every result transaction
// with an independent tree model and checks each one field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_child_list_builder_core_tb;

  import tclb_pkg::*;

  localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;
  localparam int unsigned NUM_MASK      = 'h7FF;
  localparam int unsigned IDX_MASK      = 'h3FF;

  class tree_scoreboard;
    int          parent_of[MAX_NODES];
    bit          has_parent[MAX_NODES];
    int unsigned kid_count[SLOT_DEPTH];
    int unsigned kid_offset[SLOT_DEPTH];
    int unsigned kid_list[MAX_NODES];
    bit          lists_ready;
    int unsigned leaf_reg;
    int unsigned height_reg;
    int          node_limit;
    rsp_t        pending[$];
    int          errors;

    function new();
      node_limit = MAX_NODES;
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      for (int i = 0; i < MAX_NODES; i++) begin
        parent_of[i] = -1;
        has_parent[i] = 0;
        kid_list[i] = 0;
      end
      for (int i = 0; i < SLOT_DEPTH; i++) begin
        kid_count[i] = 0;
        kid_offset[i] = 0;
      end
      lists_ready = 0;
      leaf_reg = 0;
      height_reg = 0;
    endfunction

    function void set_node_count(int unsigned value);
      node_limit = (value > MAX_NODES) ? MAX_NODES : value;
      wipe();
    endfunction

    function int depth_of(int node);
      int d;
      int cur;
      int p;
      if (node < 0) return 0;
      d = 1;
      cur = node;
      while (1) begin
        if (cur < 0 || cur >= node_limit) return -1;
        p = parent_of[cur];
        if (p == -1) return d;
        if (d >= node_limit) return -1;
        d++;
        cur = p;
      end
    endfunction

    function void sum_offsets();
      kid_offset[0] = 0;
      for (int k = 0; k < node_limit; k++)
        kid_offset[k + 1] = (kid_offset[k] + kid_count[k]) & NUM_MASK;
    endfunction

    function status_t build_lists();
      int unsigned leaves;
      int unsigned tallest;
      int unsigned s;
      int unsigned pos;
      int d;
      leaves = 0;
      tallest = 0;
      for (int i = 0; i < node_limit; i++)
        if (!has_parent[i] || parent_of[i] < -1 || parent_of[i] >= node_limit)
          return STS_MISMATCH;
      sum_offsets();
      for (int i = 0; i < node_limit; i++) begin
        s = parent_of[i] + 1;
        pos = kid_offset[s];
        kid_offset[s] = (pos + 1) & NUM_MASK;
        if (pos < MAX_NODES) kid_list[pos] = i & IDX_MASK;
      end
      sum_offsets();
      for (int i = 0; i < node_limit; i++) begin
        d = depth_of(i);
        if (d < 0) begin
          lists_ready = 0;
          return STS_CYCLE;
        end
        if (d > tallest) tallest = d;
        if (kid_count[i + 1] == 0) leaves++;
      end
      leaf_reg = leaves & NUM_MASK;
      height_reg = tallest & NUM_MASK;
      lists_ready = 1;
      return STS_OK;
    endfunction

    function void note_request(logic [2:0] req, logic [10:0] node_b, logic [10:0] par_b,
                               logic [9:0] slot);
      rsp_t exp;
      int nd;
      int pa;
      int d;
      nd = $signed(node_b);
      pa = $signed(par_b);
      exp = '0;
      exp.status = STS_OK;
      case (req)
        REQ_SET_PARENT: begin
          if (nd < 0 || nd >= node_limit || pa < -1 || pa >= node_limit) begin
            exp.status = STS_RANGE;
          end else if (has_parent[nd]) begin
            exp.status = STS_TWICE;
          end else begin
            parent_of[nd] = pa;
            has_parent[nd] = 1;
            if (kid_count[pa + 1] < NUM_MASK) kid_count[pa + 1]++;
            lists_ready = 0;
          end
        end
        REQ_BUILD: exp.status = build_lists();
        REQ_READ_SLOT: begin
          if (int'(slot) >= node_limit) exp.status = STS_RANGE;
          else if (!lists_ready) exp.status = STS_MISMATCH;
          else exp.child_node = kid_list[slot] & IDX_MASK;
        end
        REQ_QUERY: begin
          if (nd < -1 || nd >= node_limit) begin
            exp.status = STS_RANGE;
          end else if (!lists_ready) begin
            exp.status = STS_MISMATCH;
          end else begin
            d = depth_of(nd);
            if (d < 0) begin
              exp.status = STS_CYCLE;
            end else begin
              exp.child_count = kid_count[nd + 1] & NUM_MASK;
              exp.first_child = kid_offset[nd + 1] & NUM_MASK;
              exp.depth = d & NUM_MASK;
            end
          end
        end
        REQ_CLEAR: wipe();
        default: exp.status = STS_RANGE;
      endcase
      exp.leaf_total = lists_ready ? leaf_reg : 0;
      exp.tree_height = lists_ready ? height_reg : 0;
      pending.push_back(exp);
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result transaction: %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status || got.child_node !== exp.child_node ||
          got.child_count !== exp.child_count || got.first_child !== exp.first_child ||
          got.depth !== exp.depth || got.leaf_total !== exp.leaf_total ||
          got.tree_height !== exp.tree_height) begin
        errors++;
        if (errors <= 10) $display("Result mismatch: expected %p, got %p", exp, got);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [10:0] cfg_node_count = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  in_req_type = '0;
  logic [10:0] in_node = '0;
  logic [10:0] in_parent = '0;
  logic [9:0]  in_slot = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  out_status;
  logic [9:0]  out_child_node;
  logic [10:0] out_child_count;
  logic [10:0] out_first_child;
  logic [10:0] out_depth;
  logic [10:0] out_leaf_total;
  logic [10:0] out_tree_height;

  tree_scoreboard sb = new();
  int requests_sent = 0;
  int send_gap_pct = 7;
  int recv_stall_pct = 70;

  tree_child_list_builder_core DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_node_count(cfg_node_count),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_node(in_node), .in_parent(in_parent), .in_slot(in_slot),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_child_node(out_child_node), .out_child_count(out_child_count),
    .out_first_child(out_first_child), .out_depth(out_depth),
    .out_leaf_total(out_leaf_total), .out_tree_height(out_tree_height)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    rsp_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status = status_t'(out_status);
      got.child_node = out_child_node;
      got.child_count = out_child_count;
      got.first_child = out_first_child;
      got.depth = out_depth;
      got.leaf_total = out_leaf_total;
      got.tree_height = out_tree_height;
      sb.check_result(got);
    end
  end

  task automatic send_request(logic [2:0] req, int node, int parent, int slot);
    if (requests_sent < 500) begin
      send_gap_pct = 7;
      recv_stall_pct = 70;
    end else if (requests_sent < 1000) begin
      send_gap_pct = 70;
      recv_stall_pct = 7;
    end else begin
      send_gap_pct = 0;
      recv_stall_pct = 0;
    end
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    in_req_type <= req;
    in_node <= 11'(node);
    in_parent <= 11'(parent);
    in_slot <= 10'(slot);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req, 11'(node), 11'(parent), 10'(slot));
    requests_sent++;
  endtask

  task automatic write_node_count(int value);
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1;
    cfg_node_count <= 11'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_node_count(value);
    cfg_valid <= 0;
  endtask

  task automatic send_noise();
    logic [2:0] req;
    req = 3'($urandom_range(0, 7));
    if (req == REQ_CLEAR && $urandom_range(9) != 0) req = REQ_QUERY;
    send_request(req, $signed(11'($urandom)), $signed(11'($urandom)), $urandom_range(0, 1023));
  endtask

  task automatic run_phase(int n);
    int order[$];
    int tmp;
    int j;
    int node;
    int parent;
    int held;
    int reps;
    write_node_count(n);
    for (int i = 0; i < n; i++) order.push_back(i);
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    held = ($urandom_range(9) == 0) ? order[$urandom_range(0, n - 1)] : -1;
    foreach (order[k]) begin
      if (n <= 64 && $urandom_range(99) < 15) send_noise();
      node = order[k];
      if (n <= 64 && $urandom_range(99) < 8) parent = $urandom_range(0, n) - 1;
      else parent = $urandom_range(0, node) - 1;
      if (node == held) continue;
      send_request(REQ_SET_PARENT, node, parent, 0);
    end
    send_request(REQ_BUILD, 0, 0, 0);
    if (held >= 0) begin
      send_request(REQ_SET_PARENT, held, -1, 0);
      send_request(REQ_BUILD, 0, 0, 0);
    end
    reps = (n < 12) ? 3 * n + 5 : 40;
    for (int r = 0; r < reps; r++) begin
      tmp = $urandom_range(99);
      if (tmp < 45) begin
        if ($urandom_range(19) == 0) node = -$urandom_range(2, 1024);
        else if ($urandom_range(19) == 0) node = $urandom_range(n, 1023);
        else node = $urandom_range(0, n) - 1;
        send_request(REQ_QUERY, node, 0, 0);
      end else if (tmp < 90) begin
        if (n < MAX_NODES && $urandom_range(9) == 0) j = $urandom_range(n, 1023);
        else j = $urandom_range(0, n - 1);
        send_request(REQ_READ_SLOT, 0, 0, j);
      end else if (tmp < 95) begin
        send_request(REQ_SET_PARENT, $urandom_range(0, n - 1), -1, 0);
      end else begin
        send_noise();
      end
    end
    if ($urandom_range(4) == 0) begin
      send_request(REQ_CLEAR, 0, 0, 0);
      send_request(REQ_BUILD, 0, 0, 0);
      send_request(REQ_QUERY, -1, 0, 0);
    end
  endtask

  initial begin
    int phases;
    int n;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_request(REQ_UNKNOWN_LO, 0, 0, 0);
    send_request(REQ_UNKNOWN_HI, -1, -1, 1023);
    send_request(REQ_QUERY, 0, 0, 0);
    write_node_count(4);
    send_request(REQ_READ_SLOT, 0, 0, 0);
    send_request(REQ_SET_PARENT, 0, -1, 0);
    send_request(REQ_SET_PARENT, -1, -1, 0);
    send_request(REQ_SET_PARENT, 4, -1, 0);
    send_request(REQ_SET_PARENT, 1, 4, 0);
    send_request(REQ_SET_PARENT, 1, -2, 0);
    send_request(REQ_SET_PARENT, 0, 1, 0);
    send_request(REQ_BUILD, 0, 0, 0);
    send_request(REQ_SET_PARENT, 1, 0, 0);
    send_request(REQ_SET_PARENT, 2, 1, 0);
    send_request(REQ_SET_PARENT, 3, 3, 0);
    send_request(REQ_BUILD, 0, 0, 0);
    send_request(REQ_QUERY, 2, 0, 0);
    send_request(REQ_CLEAR, 0, 0, 0);
    send_request(REQ_SET_PARENT, 0, -1, 0);
    send_request(REQ_SET_PARENT, 1, 0, 0);
    send_request(REQ_SET_PARENT, 2, 1, 0);
    send_request(REQ_SET_PARENT, 3, 0, 0);
    send_request(REQ_BUILD, 0, 0, 0);
    for (int s = 0; s <= 4; s++) send_request(REQ_READ_SLOT, 0, 0, s);
    for (int q = -1; q <= 4; q++) send_request(REQ_QUERY, q, 0, 0);
    send_request(REQ_QUERY, -5, 0, 0);

    run_phase(MAX_NODES);
    run_phase(1);
    phases = 2;
    while (requests_sent < 1100 || phases < 4) begin
      case ($urandom_range(0, 5))
        0: n = 2;
        1: n = 200;
        default: n = $urandom_range(3, 40);
      endcase
      run_phase(n);
      phases++;
    end

    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

@@ tree_child_list_builder_core.f @@
rtl/core/tclb_pkg.sv
rtl/core/tclb_ram.sv
rtl/core/tclb_seq.sv
rtl/core/tree_child_list_builder_core.sv
test/tree_child_list_builder_core_tb.sv
